// ===== design/rss_pkg.sv =====
// Shared constants and types for the rectangle subtract split unit.
// No dependencies.
package rss_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int MAX_PIECES     = 4;
    localparam int PIECE_IDX_W    = $clog2(MAX_PIECES);
    localparam int QUEUE_DEPTH    = 2;
    localparam int QUEUE_PTR_W    = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_stat;

endpackage

// ===== design/rss_front.sv =====
// Front end: takes a beat, cuts the subject into left/top/right/bottom pieces.
// Depends on rss_pkg.
module rss_front #(
    parameter int COORD_BITS = rss_pkg::COORD_BITS_DEF,
    parameter int ENTRY_W    = rss_pkg::MAX_PIECES * 4 * COORD_BITS + 1 + rss_pkg::PIECE_IDX_W
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_take,
    input  logic signed [COORD_BITS-1:0] i_subject_top,
    input  logic signed [COORD_BITS-1:0] i_subject_left,
    input  logic signed [COORD_BITS-1:0] i_subject_bottom,
    input  logic signed [COORD_BITS-1:0] i_subject_right,
    input  logic signed [COORD_BITS-1:0] i_cutter_top,
    input  logic signed [COORD_BITS-1:0] i_cutter_left,
    input  logic signed [COORD_BITS-1:0] i_cutter_bottom,
    input  logic signed [COORD_BITS-1:0] i_cutter_right,
    input  rss_pkg::t_queue_stat         i_qstat,
    output logic                         o_push,
    output logic [ENTRY_W-1:0]           o_entry,
    output logic                         o_busy
);

    localparam int PW = 4 * COORD_BITS;
    localparam logic signed [COORD_BITS-1:0] C_ONE = COORD_BITS'(1);

    logic                         r_valid;
    logic                         n_valid;
    logic signed [COORD_BITS-1:0] r_st, r_sl, r_sb, r_sr, r_ct, r_cl, r_cb, r_cr;

    assign o_busy  = r_valid && i_qstat.full;
    assign o_push  = r_valid && !i_qstat.full;

    always_comb begin
        n_valid = r_valid;
        if (i_take) begin
            n_valid = 1'b1;
        end else if (o_push) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_st <= i_subject_top;
            r_sl <= i_subject_left;
            r_sb <= i_subject_bottom;
            r_sr <= i_subject_right;
            r_ct <= i_cutter_top;
            r_cl <= i_cutter_left;
            r_cb <= i_cutter_bottom;
            r_cr <= i_cutter_right;
        end
    end

    // working copy shrinks after each of the left, top and right cuts
    always_comb begin
        logic signed [COORD_BITS-1:0]               wt, wl, wb, wr;
        logic [rss_pkg::PIECE_IDX_W:0]              n;
        logic [rss_pkg::MAX_PIECES-1:0][PW-1:0]     pc;
        logic [rss_pkg::PIECE_IDX_W-1:0]            last_idx;
        wt = r_st;
        wl = r_sl;
        wb = r_sb;
        wr = r_sr;
        n  = '0;
        pc = '0;
        if (r_cl > wl && r_cl <= wr) begin
            pc[n[rss_pkg::PIECE_IDX_W-1:0]] = {wt, wl, wb, r_cl - C_ONE};
            n  = n + 1'b1;
            wl = r_cl;
        end
        if (r_ct > wt && r_ct <= wb) begin
            pc[n[rss_pkg::PIECE_IDX_W-1:0]] = {wt, wl, r_ct - C_ONE, wr};
            n  = n + 1'b1;
            wt = r_ct;
        end
        if (r_cr >= wl && r_cr < wr) begin
            pc[n[rss_pkg::PIECE_IDX_W-1:0]] = {wt, r_cr + C_ONE, wb, wr};
            n  = n + 1'b1;
            wr = r_cr;
        end
        if (r_cb >= wt && r_cb < wb) begin
            pc[n[rss_pkg::PIECE_IDX_W-1:0]] = {r_cb + C_ONE, wl, wb, wr};
            n  = n + 1'b1;
        end
        if (n == '0) begin
            last_idx = '0;
        end else begin
            last_idx = rss_pkg::PIECE_IDX_W'(n - 1'b1);
        end
        o_entry = {pc, (n != '0), last_idx};
    end

endmodule

// ===== design/rss_queue.sv =====
// Short queue between the front and back ends.
// Depends on rss_pkg.
module rss_queue #(
    parameter int DATA_W = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic [DATA_W-1:0]    i_data,
    input  logic                 i_pop,
    output logic [DATA_W-1:0]    o_data,
    output rss_pkg::t_queue_stat o_stat
);

    logic [DATA_W-1:0]               r_mem [rss_pkg::QUEUE_DEPTH];
    logic [rss_pkg::QUEUE_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [rss_pkg::QUEUE_PTR_W:0]   r_count;

    assign o_stat.full  = (r_count == (rss_pkg::QUEUE_PTR_W + 1)'(rss_pkg::QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_data       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== design/rss_back.sv =====
// Back end: sends the pieces of the head entry, one beat per cycle while the queue is not empty.
// Depends on rss_pkg.
module rss_back #(
    parameter int COORD_BITS = rss_pkg::COORD_BITS_DEF,
    parameter int ENTRY_W    = rss_pkg::MAX_PIECES * 4 * COORD_BITS + 1 + rss_pkg::PIECE_IDX_W
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [ENTRY_W-1:0]           i_entry,
    input  rss_pkg::t_queue_stat         i_qstat,
    output logic                         o_pop,
    output logic                         o_strobe,
    output logic signed [COORD_BITS-1:0] o_piece_top,
    output logic signed [COORD_BITS-1:0] o_piece_left,
    output logic signed [COORD_BITS-1:0] o_piece_bottom,
    output logic signed [COORD_BITS-1:0] o_piece_right,
    output logic                         o_piece_valid,
    output logic                         o_last
);

    localparam int PW = 4 * COORD_BITS;
    localparam int IW = rss_pkg::PIECE_IDX_W;

    logic [IW-1:0]                          r_idx;
    logic [IW-1:0]                          n_idx;
    logic [IW-1:0]                          w_last_idx;
    logic                                   w_any;
    logic [rss_pkg::MAX_PIECES-1:0][PW-1:0] w_pieces;
    logic                                   w_send;
    logic                                   w_is_last;

    assign {w_pieces, w_any, w_last_idx} = i_entry;
    assign w_send    = !i_qstat.empty;
    assign w_is_last = (r_idx == w_last_idx);
    assign o_pop     = w_send && w_is_last;

    always_comb begin
        n_idx = r_idx;
        if (o_pop) begin
            n_idx = '0;
        end else if (w_send) begin
            n_idx = r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            o_strobe <= 1'b0;
        end else begin
            r_idx    <= n_idx;
            o_strobe <= w_send;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_send) begin
            {o_piece_top, o_piece_left, o_piece_bottom, o_piece_right} <= w_pieces[r_idx];
            o_piece_valid <= w_any;
            o_last        <= w_is_last;
        end
    end

endmodule

// ===== design/rectangle_subtract_split_unit.sv =====
// Top level of the rectangle subtract split unit: front end, queue, back end.
// Depends on rss_pkg, rss_front, rss_queue, rss_back.
//
// Each beat taken on start (while busy is low) yields one to four result beats on
// o_strobe, in the order left, top, right, bottom; o_last marks the final one, and a
// single beat with o_piece_valid low stands for "no piece". The result port sends
// one beat per cycle while the queue holds an entry; start may be taken on
// back-to-back cycles until the two-entry queue and the front register fill,
// and busy then follows the back end's drain. Each item passes through the front
// register and the queue before its first result. The receiver cannot stall:
// every o_strobe beat must be captured in the cycle it is shown.
module rectangle_subtract_split_unit #(
    parameter int COORD_BITS = rss_pkg::COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [COORD_BITS-1:0] i_subject_top,
    input  logic signed [COORD_BITS-1:0] i_subject_left,
    input  logic signed [COORD_BITS-1:0] i_subject_bottom,
    input  logic signed [COORD_BITS-1:0] i_subject_right,
    input  logic signed [COORD_BITS-1:0] i_cutter_top,
    input  logic signed [COORD_BITS-1:0] i_cutter_left,
    input  logic signed [COORD_BITS-1:0] i_cutter_bottom,
    input  logic signed [COORD_BITS-1:0] i_cutter_right,
    output logic                         o_strobe,
    output logic signed [COORD_BITS-1:0] o_piece_top,
    output logic signed [COORD_BITS-1:0] o_piece_left,
    output logic signed [COORD_BITS-1:0] o_piece_bottom,
    output logic signed [COORD_BITS-1:0] o_piece_right,
    output logic                         o_piece_valid,
    output logic                         o_last
);

    localparam int ENTRY_W = rss_pkg::MAX_PIECES * 4 * COORD_BITS + 1 + rss_pkg::PIECE_IDX_W;

    logic                 w_take;
    logic                 w_push;
    logic                 w_pop;
    logic [ENTRY_W-1:0]   w_wr_entry;
    logic [ENTRY_W-1:0]   w_rd_entry;
    rss_pkg::t_queue_stat w_qstat;

    assign w_take = start && !busy;

    rss_front #(
        .COORD_BITS (COORD_BITS),
        .ENTRY_W    (ENTRY_W)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_take           (w_take),
        .i_subject_top    (i_subject_top),
        .i_subject_left   (i_subject_left),
        .i_subject_bottom (i_subject_bottom),
        .i_subject_right  (i_subject_right),
        .i_cutter_top     (i_cutter_top),
        .i_cutter_left    (i_cutter_left),
        .i_cutter_bottom  (i_cutter_bottom),
        .i_cutter_right   (i_cutter_right),
        .i_qstat          (w_qstat),
        .o_push           (w_push),
        .o_entry          (w_wr_entry),
        .o_busy           (busy)
    );

    rss_queue #(
        .DATA_W (ENTRY_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_wr_entry),
        .i_pop   (w_pop),
        .o_data  (w_rd_entry),
        .o_stat  (w_qstat)
    );

    rss_back #(
        .COORD_BITS (COORD_BITS),
        .ENTRY_W    (ENTRY_W)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_entry        (w_rd_entry),
        .i_qstat        (w_qstat),
        .o_pop          (w_pop),
        .o_strobe       (o_strobe),
        .o_piece_top    (o_piece_top),
        .o_piece_left   (o_piece_left),
        .o_piece_bottom (o_piece_bottom),
        .o_piece_right  (o_piece_right),
        .o_piece_valid  (o_piece_valid),
        .o_last         (o_last)
    );

endmodule

// ===== tb/rss_split_checker.sv =====
`timescale 1ns / 1ps
// Checker for the rectangle subtract split unit: watches the item and result ports,
// predicts the split pieces of each accepted item and compares every result beat.
// Depends on rss_pkg.
module rss_split_checker #(
    parameter int CW = rss_pkg::COORD_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic                 i_busy,
    input  logic signed [CW-1:0] i_subject_top,
    input  logic signed [CW-1:0] i_subject_left,
    input  logic signed [CW-1:0] i_subject_bottom,
    input  logic signed [CW-1:0] i_subject_right,
    input  logic signed [CW-1:0] i_cutter_top,
    input  logic signed [CW-1:0] i_cutter_left,
    input  logic signed [CW-1:0] i_cutter_bottom,
    input  logic signed [CW-1:0] i_cutter_right,
    input  logic                 i_strobe,
    input  logic signed [CW-1:0] i_piece_top,
    input  logic signed [CW-1:0] i_piece_left,
    input  logic signed [CW-1:0] i_piece_bottom,
    input  logic signed [CW-1:0] i_piece_right,
    input  logic                 i_piece_valid,
    input  logic                 i_last,
    output int                   o_fail_count,
    output int                   o_pending
);

    typedef struct packed {
        logic signed [CW-1:0] top;
        logic signed [CW-1:0] left;
        logic signed [CW-1:0] bottom;
        logic signed [CW-1:0] right;
        logic                 valid;
        logic                 last;
    } t_piece;

    t_piece expected_pieces[$];
    int     fail_count    = 0;
    int     pending_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_count;

    task automatic report_mismatch(input string msg);
        fail_count++;
        if (fail_count <= 40) begin
            $display("ERROR %0t: %s", $time, msg);
        end
    endtask

    function automatic t_piece make_piece(input longint t, input longint l,
                                          input longint b, input longint r);
        t_piece p;
        p.top    = t[CW-1:0];
        p.left   = l[CW-1:0];
        p.bottom = b[CW-1:0];
        p.right  = r[CW-1:0];
        p.valid  = 1'b1;
        p.last   = 1'b0;
        return p;
    endfunction

    // Left, top, right, bottom cuts; each cut shrinks the working rectangle.
    task automatic predict_split();
        longint wt, wl, wb, wr, ct, cl, cb, cr;
        t_piece batch[4];
        int     n;
        wt = i_subject_top;
        wl = i_subject_left;
        wb = i_subject_bottom;
        wr = i_subject_right;
        ct = i_cutter_top;
        cl = i_cutter_left;
        cb = i_cutter_bottom;
        cr = i_cutter_right;
        n  = 0;
        if (cl > wl && cl <= wr) begin
            batch[n] = make_piece(wt, wl, wb, cl - 1);
            n++;
            wl = cl;
        end
        if (ct > wt && ct <= wb) begin
            batch[n] = make_piece(wt, wl, ct - 1, wr);
            n++;
            wt = ct;
        end
        if (cr >= wl && cr < wr) begin
            batch[n] = make_piece(wt, cr + 1, wb, wr);
            n++;
            wr = cr;
        end
        if (cb >= wt && cb < wb) begin
            batch[n] = make_piece(cb + 1, wl, wb, wr);
            n++;
            wb = cb;
        end
        if (n == 0) begin
            batch[0]       = make_piece(0, 0, 0, 0);
            batch[0].valid = 1'b0;
            n              = 1;
        end
        batch[n-1].last = 1'b1;
        for (int k = 0; k < n; k++) begin
            expected_pieces.push_back(batch[k]);
        end
    endtask

    always @(posedge i_clk) begin
        t_piece want;
        if (i_rst_n) begin
            if (i_strobe) begin
                if (expected_pieces.size() == 0) begin
                    report_mismatch("result beat with no item pending");
                end else begin
                    want = expected_pieces.pop_front();
                    if (i_piece_top !== want.top)
                        report_mismatch($sformatf("piece_top got %0d expected %0d",
                                                  i_piece_top, want.top));
                    if (i_piece_left !== want.left)
                        report_mismatch($sformatf("piece_left got %0d expected %0d",
                                                  i_piece_left, want.left));
                    if (i_piece_bottom !== want.bottom)
                        report_mismatch($sformatf("piece_bottom got %0d expected %0d",
                                                  i_piece_bottom, want.bottom));
                    if (i_piece_right !== want.right)
                        report_mismatch($sformatf("piece_right got %0d expected %0d",
                                                  i_piece_right, want.right));
                    if (i_piece_valid !== want.valid)
                        report_mismatch($sformatf("piece_valid got %b expected %b",
                                                  i_piece_valid, want.valid));
                    if (i_last !== want.last)
                        report_mismatch($sformatf("last got %b expected %b",
                                                  i_last, want.last));
                end
            end
            if (i_start && !i_busy) begin
                predict_split();
            end
        end
        pending_count = expected_pieces.size();
    end

endmodule

// ===== tb/rectangle_subtract_split_unit_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the rectangle subtract split unit: clock, reset, directed and
// random item stimulus, and the verdict. Depends on rss_pkg, the unit and rss_split_checker.
module rectangle_subtract_split_unit_tb;

    localparam int     CW       = rss_pkg::COORD_BITS_DEF;
    localparam longint COORD_LO = -(longint'(1) << (CW - 1));
    localparam longint COORD_HI = (longint'(1) << (CW - 1)) - 1;
    localparam logic [CW-1:0] PAT_A = {(CW/2){2'b01}};
    localparam logic [CW-1:0] PAT_B = {(CW/2){2'b10}};

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic signed [CW-1:0] subject_top;
    logic signed [CW-1:0] subject_left;
    logic signed [CW-1:0] subject_bottom;
    logic signed [CW-1:0] subject_right;
    logic signed [CW-1:0] cutter_top;
    logic signed [CW-1:0] cutter_left;
    logic signed [CW-1:0] cutter_bottom;
    logic signed [CW-1:0] cutter_right;
    logic                 strobe;
    logic signed [CW-1:0] piece_top;
    logic signed [CW-1:0] piece_left;
    logic signed [CW-1:0] piece_bottom;
    logic signed [CW-1:0] piece_right;
    logic                 piece_valid;
    logic                 last;
    int                   fail_count;
    int                   pending;
    bit                   idle_en;

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    rectangle_subtract_split_unit #(
        .COORD_BITS(CW)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_subject_top   (subject_top),
        .i_subject_left  (subject_left),
        .i_subject_bottom(subject_bottom),
        .i_subject_right (subject_right),
        .i_cutter_top    (cutter_top),
        .i_cutter_left   (cutter_left),
        .i_cutter_bottom (cutter_bottom),
        .i_cutter_right  (cutter_right),
        .o_strobe        (strobe),
        .o_piece_top     (piece_top),
        .o_piece_left    (piece_left),
        .o_piece_bottom  (piece_bottom),
        .o_piece_right   (piece_right),
        .o_piece_valid   (piece_valid),
        .o_last          (last)
    );

    rss_split_checker #(
        .CW(CW)
    ) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_subject_top   (subject_top),
        .i_subject_left  (subject_left),
        .i_subject_bottom(subject_bottom),
        .i_subject_right (subject_right),
        .i_cutter_top    (cutter_top),
        .i_cutter_left   (cutter_left),
        .i_cutter_bottom (cutter_bottom),
        .i_cutter_right  (cutter_right),
        .i_strobe        (strobe),
        .i_piece_top     (piece_top),
        .i_piece_left    (piece_left),
        .i_piece_bottom  (piece_bottom),
        .i_piece_right   (piece_right),
        .i_piece_valid   (piece_valid),
        .i_last          (last),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    // Drive one item beat at a falling edge, hold until taken.
    task automatic send_rect(input longint st, input longint sl,
                             input longint sb, input longint sr,
                             input longint ct, input longint cl,
                             input longint cb, input longint cr);
        @(negedge i_clk);
        while (idle_en && $urandom_range(0, 99) < 32) begin
            start = 1'b0;
            @(negedge i_clk);
        end
        start          = 1'b1;
        subject_top    = st[CW-1:0];
        subject_left   = sl[CW-1:0];
        subject_bottom = sb[CW-1:0];
        subject_right  = sr[CW-1:0];
        cutter_top     = ct[CW-1:0];
        cutter_left    = cl[CW-1:0];
        cutter_bottom  = cb[CW-1:0];
        cutter_right   = cr[CW-1:0];
        do @(posedge i_clk); while (busy);
    endtask

    task automatic send_noise_item();
        logic [31:0] r[8];
        for (int k = 0; k < 8; k++) begin
            r[k] = $urandom;
        end
        send_rect(longint'(r[0]), longint'(r[1]), longint'(r[2]), longint'(r[3]),
                  longint'(r[4]), longint'(r[5]), longint'(r[6]), longint'(r[7]));
    endtask

    // Subject and cutter drawn from one small window so edges often touch.
    task automatic send_window_item();
        longint base;
        longint span;
        longint c[8];
        longint tmp;
        span = $urandom_range(3, 63);
        case ($urandom_range(0, 9))
            0: begin
                base = COORD_LO;
            end
            1: begin
                base = COORD_HI - span;
            end
            default: begin
                base = COORD_LO + longint'($urandom_range(0, 2**CW - 64));
            end
        endcase
        for (int k = 0; k < 8; k++) begin
            c[k] = base + longint'($urandom_range(0, span));
        end
        for (int k = 0; k < 2; k++) begin
            if (c[k] > c[k+2]) begin
                tmp    = c[k];
                c[k]   = c[k+2];
                c[k+2] = tmp;
            end
            if ($urandom_range(0, 9) != 0 && c[k+4] > c[k+6]) begin
                tmp    = c[k+4];
                c[k+4] = c[k+6];
                c[k+6] = tmp;
            end
        end
        send_rect(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]);
    endtask

    initial begin
        i_rst_n        = 1'b0;
        start          = 1'b0;
        subject_top    = '0;
        subject_left   = '0;
        subject_bottom = '0;
        subject_right  = '0;
        cutter_top     = '0;
        cutter_left    = '0;
        cutter_bottom  = '0;
        cutter_right   = '0;
        idle_en        = 1'b1;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // all four cuts, cutter covers subject, cutter equals subject
        send_rect(-10, -10, 10, 10, -5, -5, 5, 5);
        send_rect(-5, -5, 5, 5, -10, -10, 10, 10);
        send_rect(0, 0, 7, 7, 0, 0, 7, 7);
        // one cut at a time
        send_rect(0, 0, 7, 7, 0, 4, 7, 7);
        send_rect(0, 0, 7, 7, 4, 0, 7, 7);
        send_rect(0, 0, 7, 7, 0, 0, 7, 3);
        send_rect(0, 0, 7, 7, 0, 0, 3, 7);
        // cutter clear of the subject
        send_rect(0, 0, 7, 7, 0, 20, 7, 30);
        send_rect(0, 0, 7, 7, 20, 2, 30, 5);
        // inverted rectangles
        send_rect(7, 0, 0, 7, 2, 2, 5, 5);
        send_rect(0, 0, 7, 7, 5, 5, 2, 2);
        // coordinate extremes
        send_rect(COORD_LO, COORD_LO, COORD_HI, COORD_HI,
                  COORD_LO + 1, COORD_LO + 1, COORD_HI - 1, COORD_HI - 1);
        send_rect(COORD_LO, COORD_LO, COORD_HI, COORD_HI,
                  COORD_LO, COORD_LO, COORD_LO, COORD_LO);
        send_rect(COORD_LO, COORD_LO, COORD_HI, COORD_HI,
                  COORD_HI, COORD_HI, COORD_HI, COORD_HI);
        send_rect(COORD_LO, COORD_LO, COORD_HI, COORD_HI,
                  COORD_LO, COORD_LO, COORD_HI, COORD_HI);
        send_rect(COORD_LO, COORD_LO, COORD_HI, COORD_HI, 0, 0, 0, 0);
        send_rect(COORD_LO, COORD_LO, COORD_LO, COORD_LO,
                  COORD_LO, COORD_LO, COORD_LO, COORD_LO);
        send_rect(COORD_HI, COORD_HI, COORD_HI, COORD_HI,
                  COORD_HI, COORD_HI, COORD_HI, COORD_HI);
        send_rect(3, 3, 3, 3, 3, 3, 3, 3);
        send_rect(longint'(PAT_B), longint'(PAT_B), longint'(PAT_A), longint'(PAT_A),
                  longint'(PAT_A), longint'(PAT_A), longint'(PAT_B), longint'(PAT_B));
        send_rect(longint'(PAT_A), longint'(PAT_A), longint'(PAT_B), longint'(PAT_B),
                  longint'(PAT_B), longint'(PAT_B), longint'(PAT_A), longint'(PAT_A));

        for (int n = 0; n < 320; n++) begin
            idle_en = !(n >= 120 && n < 200);
            if ($urandom_range(0, 99) < 15) begin
                send_noise_item();
            end else begin
                send_window_item();
            end
        end
        @(negedge i_clk);
        start = 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (12) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("ERROR: timeout");
        $display("Test completed with failures");
        $finish;
    end

endmodule
